### hdl/lpsu_pkg.sv
// Shared types and constants for the LCD pixel shadow update block.
// Depends on nothing; lpsu_seq, lpsu_out and the top level refer to it by scoped names.
package lpsu_pkg;

   localparam int COLUMNS = 84;
   localparam int ROWS    = 48;
   localparam int BANKS   = ROWS / 8;
   localparam int DEPTH   = COLUMNS * BANKS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int BANK_W  = (BANKS > 1) ? $clog2(BANKS) : 1;
   localparam int STEP_W  = $clog2(BANKS + 3);

   localparam logic [1:0] ACT_SET   = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_VLINE = 2'd2;

   localparam logic [7:0] CMD_SET_X    = 8'h80;
   localparam logic [7:0] CMD_SET_Y    = 8'h40;
   localparam logic [7:0] CMD_VERTICAL = 8'd34;
   localparam logic [7:0] FULL_BYTE    = 8'hFF;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_data;
      logic       status;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

endpackage

### hdl/lpsu_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module lpsu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/lpsu_seq.sv
// Request sequencer: clears the shadow RAM after reset, does the pixel
// read-modify-write and line fill, and steps through the response bytes.
// Depends on lpsu_pkg.
module lpsu_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_action,
   input  logic [7:0]            req_x_pos,
   input  logic [7:0]            req_y_pos,
   output logic                  req_stall,
   output lpsu_pkg::ram_req_type ram_req,
   input  logic [7:0]            ram_rd_data,
   output logic                  emit_valid,
   output lpsu_pkg::rsp_item_type emit_item,
   input  logic                  emit_ready
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   localparam logic [1:0] KIND_PIXEL = 2'd0;
   localparam logic [1:0] KIND_LINE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam int AW = lpsu_pkg::ADDR_W;
   localparam int BW = lpsu_pkg::BANK_W;
   localparam int SW = lpsu_pkg::STEP_W;

   logic [1:0]    state_ff, state_in;
   logic [1:0]    kind_ff, kind_in;
   logic          clr_ff, clr_in;
   logic [7:0]    x_ff, x_in;
   logic [BW-1:0] bank_ff, bank_in;
   logic [2:0]    bit_ff, bit_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [SW-1:0] step_ff, step_in;
   logic [7:0]    data_ff, data_in;

   logic          x_ok, y_ok;
   logic [BW-1:0] req_bank;
   logic [AW-1:0] line_base, pix_addr;
   logic [7:0]    mask, new_byte;

   assign x_ok      = req_x_pos < 8'(lpsu_pkg::COLUMNS);
   assign y_ok      = req_y_pos < 8'(lpsu_pkg::ROWS);
   assign req_bank  = BW'(req_y_pos[7:3]);
   assign line_base = AW'(AW'(req_x_pos) * AW'(lpsu_pkg::BANKS));
   assign pix_addr  = AW'(line_base + AW'(req_bank));
   assign mask      = 8'(8'd1 << bit_ff);
   assign new_byte  = clr_ff ? (ram_rd_data & ~mask) : (ram_rd_data | mask);
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      clr_in     = clr_ff;
      x_in       = x_ff;
      bank_in    = bank_ff;
      bit_in     = bit_ff;
      addr_in    = addr_ff;
      step_in    = step_ff;
      data_in    = data_ff;
      ram_req    = '0;
      emit_valid = 1'b0;
      emit_item  = '0;

      // Pick the byte that goes out at the current step.
      case (kind_ff)
         KIND_PIXEL: begin
            if (step_ff == SW'(0)) begin
               emit_item.out_byte = lpsu_pkg::CMD_SET_X | x_ff;
            end else if (step_ff == SW'(1)) begin
               emit_item.out_byte = lpsu_pkg::CMD_SET_Y | 8'(bank_ff);
            end else begin
               emit_item.out_byte = data_ff;
               emit_item.is_data  = 1'b1;
               emit_item.last     = 1'b1;
            end
         end
         KIND_LINE: begin
            if (step_ff == SW'(0)) begin
               emit_item.out_byte = lpsu_pkg::CMD_VERTICAL;
            end else if (step_ff == SW'(1)) begin
               emit_item.out_byte = lpsu_pkg::CMD_SET_Y;
            end else if (step_ff == SW'(2)) begin
               emit_item.out_byte = lpsu_pkg::CMD_SET_X | x_ff;
            end else begin
               emit_item.out_byte = lpsu_pkg::FULL_BYTE;
               emit_item.is_data  = 1'b1;
               emit_item.last     = (step_ff == SW'(lpsu_pkg::BANKS + 2));
            end
         end
         default: begin
            emit_item.status = 1'b1;
            emit_item.last   = 1'b1;
         end
      endcase

      case (state_ff)
         ST_CLEAR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = addr_ff;
            ram_req.wr_data = 8'd0;
            if (addr_ff == AW'(lpsu_pkg::DEPTH - 1)) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = AW'(addr_ff + AW'(1));
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               x_in    = req_x_pos;
               bank_in = req_bank;
               bit_in  = req_y_pos[2:0];
               clr_in  = (req_action == lpsu_pkg::ACT_CLEAR);
               step_in = '0;
               if ((req_action == lpsu_pkg::ACT_SET || req_action == lpsu_pkg::ACT_CLEAR)
                   && x_ok && y_ok) begin
                  kind_in         = KIND_PIXEL;
                  addr_in         = pix_addr;
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = pix_addr;
                  state_in        = ST_READ;
               end else if (req_action == lpsu_pkg::ACT_VLINE && x_ok) begin
                  kind_in  = KIND_LINE;
                  addr_in  = line_base;
                  state_in = ST_EMIT;
               end else begin
                  kind_in  = KIND_ERROR;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_READ: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = addr_ff;
            ram_req.wr_data = new_byte;
            data_in         = new_byte;
            state_in        = ST_EMIT;
         end
         ST_EMIT: begin
            emit_valid = 1'b1;
            if (emit_ready) begin
               step_in = SW'(step_ff + SW'(1));
               // Each line data byte fills the next bank of the column.
               if (kind_ff == KIND_LINE && step_ff > SW'(2)) begin
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = addr_ff;
                  ram_req.wr_data = lpsu_pkg::FULL_BYTE;
                  addr_in         = AW'(addr_ff + AW'(1));
               end
               if (emit_item.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
         step_ff  <= '0;
         kind_ff  <= KIND_ERROR;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         step_ff  <= step_in;
         kind_ff  <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      clr_ff  <= clr_in;
      x_ff    <= x_in;
      bank_ff <= bank_in;
      bit_ff  <= bit_in;
      data_ff <= data_in;
   end

   a_read_then_write: assert property (@(posedge clock) disable iff (reset)
      ram_req.rd_en |=> ram_req.wr_en && ram_req.wr_addr == $past(ram_req.rd_addr))
      else $error("pixel read was not followed by its write-back");

   a_no_read_write_overlap: assert property (@(posedge clock) disable iff (reset)
      ram_req.rd_en |-> !ram_req.wr_en)
      else $error("read and write issued in the same cycle");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !emit_valid && !ram_req.wr_en)
      else $error("activity while waiting for a request");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |-> ram_req.wr_addr <= AW'(lpsu_pkg::DEPTH - 1))
      else $error("shadow write beyond the display");

endmodule

### hdl/lpsu_out.sv
// Response output register: holds one byte for the LCD link until taken.
// Depends on lpsu_pkg.
module lpsu_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  lpsu_pkg::rsp_item_type in_item,
   output logic                   in_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_is_data,
   output logic                   rsp_status,
   output logic                   rsp_last
);

   logic                   valid_ff, valid_in;
   lpsu_pkg::rsp_item_type item_ff, item_in;

   assign in_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
         item_in  = in_item;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = item_ff.out_byte;
   assign rsp_is_data  = item_ff.is_data;
   assign rsp_status   = item_ff.status;
   assign rsp_last     = item_ff.last;

endmodule

### hdl/lcd_pixel_shadow_update.sv
// Keeps a shadow of an 84 x 48 monochrome LCD (84 columns by 6 banks of 8 rows) and turns
// set-pixel, clear-pixel and vertical-line requests into the command and data bytes for
// the display link. After reset the shadow RAM is cleared, one byte a cycle, through all
// 504 bytes, during which req_stall stays high. A pixel request is then accepted with a
// RAM read, written back, and sent as three bytes; a vertical line sends nine bytes, the
// column being filled as its data bytes go out; an out-of-range or unknown request sends
// one status byte. One request is processed at a time; the shadow RAM read is registered
// ahead of the write-back, and response bytes go one per cycle while rsp_stall is low. A
// finished byte sits in an output register, so a new request can be taken while the last
// byte still waits on rsp_stall.
// Depends on lpsu_pkg, lpsu_ram, lpsu_seq and lpsu_out.
module lcd_pixel_shadow_update (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_action,
   input  logic [7:0] req_x_pos,
   input  logic [7:0] req_y_pos,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_data,
   output logic       rsp_status,
   output logic       rsp_last
);

   lpsu_pkg::ram_req_type  ram_req;
   logic [7:0]             ram_rd_data;
   logic                   emit_valid;
   logic                   emit_ready;
   lpsu_pkg::rsp_item_type emit_item;

   lpsu_ram #(
      .WIDTH (8),
      .DEPTH (lpsu_pkg::DEPTH)
   ) u_shadow_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   lpsu_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_action  (req_action),
      .req_x_pos   (req_x_pos),
      .req_y_pos   (req_y_pos),
      .req_stall   (req_stall),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data),
      .emit_valid  (emit_valid),
      .emit_item   (emit_item),
      .emit_ready  (emit_ready)
   );

   lpsu_out u_out (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (emit_valid),
      .in_item      (emit_item),
      .in_ready     (emit_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_data  (rsp_is_data),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

endmodule
